>>> sv/thq_pkg.sv
// Package for the touch hold qualifier: widths, phase and outcome codes,
// controller states, register indexes and reset values, and the reciprocal table.
// No dependencies.
package thq_pkg;

  localparam int unsigned COORD_W      = 12;
  localparam int unsigned TIME_W       = 32;
  localparam int unsigned MS_W         = 16;
  localparam int unsigned CNT_W        = 3;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned POINT_FIELDS = 4;
  localparam int unsigned SUM_W        = COORD_W + $clog2(POINT_FIELDS);
  localparam int unsigned RECIP_SHIFT  = 16;
  localparam int unsigned RECIP_W      = RECIP_SHIFT + 1;
  localparam int unsigned PROD_W       = SUM_W + RECIP_W;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [TIME_W-1:0]  time_t;
  typedef logic [MS_W-1:0]    ms_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [SUM_W-1:0]   sum_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_TSTART = 3'd1,
    PH_TPROG  = 3'd2,
    PH_GSTART = 3'd3,
    PH_GPROG  = 3'd4,
    PH_DET    = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    OUT_DETECTED = 2'd0,
    OUT_ABANDON  = 2'd1,
    OUT_TIMEOUT  = 2'd2
  } outcome_e;

  typedef enum logic [1:0] {
    CTL_IDLE = 2'd0,
    CTL_SUM  = 2'd1,
    CTL_MUL  = 2'd2,
    CTL_STEP = 2'd3
  } ctl_e;

  localparam logic [0:0] OP_START = 1'b0;

  localparam logic [CFG_IDX_W-1:0] CFG_HOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

  localparam ms_t   HOLD_RST    = 16'd120;
  localparam ms_t   GAP_RST     = 16'd30;
  localparam time_t TIMEOUT_RST = 32'd180000;

  // Control from the sequencer to the merging stage.
  typedef struct packed {
    logic sum_en;
    logic mul_en;
  } merge_ctl_t;

  // Rounded-up reciprocal of the point count, scaled by 2^RECIP_SHIFT.
  // For sums below 2^15 the product shifted right is the exact truncated mean.
  function automatic logic [RECIP_W-1:0] recip(input cnt_t cnt);
    logic [RECIP_W-1:0] r;
    case (cnt)
      3'd1:    r = 17'd65536;
      3'd2:    r = 17'd32768;
      3'd3:    r = 17'd21846;
      3'd4:    r = 17'd16384;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> sv/thq_if.sv
// Handshake interfaces of the touch hold qualifier: poll items, results, register writes.
// Depends on thq_pkg.
interface thq_in_if;
  import thq_pkg::*;
  logic        valid;
  logic        ready;
  logic        op;
  time_t       now_ms;
  cnt_t        point_count;
  coord_t      x0, x1, x2, x3;
  coord_t      y0, y1, y2, y3;
  modport source (output valid, op, now_ms, point_count, x0, x1, x2, x3, y0, y1, y2, y3,
                  input ready);
  modport sink (input valid, op, now_ms, point_count, x0, x1, x2, x3, y0, y1, y2, y3,
                output ready);
endinterface

interface thq_out_if;
  import thq_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] outcome;
  coord_t     x_out;
  coord_t     y_out;
  modport source (output valid, outcome, x_out, y_out, input ready);
  modport sink (input valid, outcome, x_out, y_out, output ready);
endinterface

interface thq_cfg_if;
  import thq_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TIME_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> sv/thq_lane.sv
// One point lane: captures a touch point, zeroed when the point is not valid.
// Depends on thq_pkg.
module thq_lane (
  input  logic            clk_i,
  input  logic            load_i,
  input  logic            en_i,
  input  thq_pkg::coord_t x_i,
  input  thq_pkg::coord_t y_i,
  output thq_pkg::coord_t x_o,
  output thq_pkg::coord_t y_o
);
  import thq_pkg::*;

  coord_t x_q, x_d;
  coord_t y_q, y_d;

  always_comb begin
    x_d = en_i ? x_i : '0;
    y_d = en_i ? y_i : '0;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
endmodule

>>> sv/thq_merge.sv
// Merging stage: sums the lanes, then scales the sums by the reciprocal of the count.
// Depends on thq_pkg.
module thq_merge #(
  parameter int unsigned LANES = 4
) (
  input  logic                clk_i,
  input  thq_pkg::merge_ctl_t ctl_i,
  input  thq_pkg::cnt_t       cnt_i,
  input  thq_pkg::coord_t     x_i [LANES],
  input  thq_pkg::coord_t     y_i [LANES],
  output thq_pkg::coord_t     avg_x_o,
  output thq_pkg::coord_t     avg_y_o
);
  import thq_pkg::*;

  sum_t sum_x_q, sum_x_d;
  sum_t sum_y_q, sum_y_d;
  logic [PROD_W-1:0] prod_x_q, prod_x_d;
  logic [PROD_W-1:0] prod_y_q, prod_y_d;

  always_comb begin
    sum_x_d = '0;
    sum_y_d = '0;
    for (int i = 0; i < LANES; i++) begin
      sum_x_d = sum_x_d + SUM_W'(x_i[i]);
      sum_y_d = sum_y_d + SUM_W'(y_i[i]);
    end
    prod_x_d = PROD_W'(sum_x_q) * PROD_W'(recip(cnt_i));
    prod_y_d = PROD_W'(sum_y_q) * PROD_W'(recip(cnt_i));
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.sum_en) begin
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
    end
    if (ctl_i.mul_en) begin
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
    end
  end

  assign avg_x_o = prod_x_q[RECIP_SHIFT +: COORD_W];
  assign avg_y_o = prod_y_q[RECIP_SHIFT +: COORD_W];
endmodule

>>> sv/touch_hold_qualifier.sv
// Touch hold qualifier top level: point lanes, merging stage, sequencer and hold state machine.
// Each item goes through capture, lane sum, reciprocal scaling and state step in that order;
// the sequencer takes one item at a time, and the result is registered after the state step.
// A waiting result does not block the input, but the next state step stalls until it is read.
// Reset (rst_ni, asynchronous, active low) clears the session, the phase, the output valid
// and restores the register defaults (hold 120 ms, gap 30 ms, timeout 180000 ms).
module touch_hold_qualifier #(
  parameter int unsigned MAX_POINTS = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  thq_in_if.sink    item_i,
  thq_out_if.source result_o,
  thq_cfg_if.sink   cfg_i
);
  import thq_pkg::*;

  // Only as many lanes as there are both point fields and allowed points.
  localparam int unsigned LANES = (MAX_POINTS < POINT_FIELDS) ? MAX_POINTS : POINT_FIELDS;

  // Configuration registers. Writes are always taken.
  ms_t   hold_q;
  ms_t   gap_q;
  time_t timeout_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q    <= HOLD_RST;
      gap_q     <= GAP_RST;
      timeout_q <= TIMEOUT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_HOLD:    hold_q    <= cfg_i.data[MS_W-1:0];
        CFG_GAP:     gap_q     <= cfg_i.data[MS_W-1:0];
        CFG_TIMEOUT: timeout_q <= cfg_i.data;
        default:     ;
      endcase
    end
  end

  // Sequencer. The item is accepted only in idle; the sequencer then
  // sums the lanes, scales by the count and steps the state machine.
  ctl_e ctl_q, ctl_d;
  logic item_acc;
  logic step_go;
  merge_ctl_t merge_ctl;

  assign item_i.ready = (ctl_q == CTL_IDLE);
  assign item_acc     = item_i.valid && item_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= CTL_IDLE;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_comb begin
    ctl_d            = ctl_q;
    merge_ctl.sum_en = 1'b0;
    merge_ctl.mul_en = 1'b0;
    case (ctl_q)
      CTL_IDLE: begin
        if (item_acc) ctl_d = CTL_SUM;
      end
      CTL_SUM: begin
        merge_ctl.sum_en = 1'b1;
        ctl_d            = CTL_MUL;
      end
      CTL_MUL: begin
        merge_ctl.mul_en = 1'b1;
        ctl_d            = CTL_STEP;
      end
      CTL_STEP: begin
        if (step_go) ctl_d = CTL_IDLE;
      end
      default: ctl_d = CTL_IDLE;
    endcase
  end

  // Captured item fields. The count is clamped to the number of lanes.
  logic  op_q;
  time_t now_q;
  cnt_t  cnt_q, cnt_d;

  assign cnt_d = (item_i.point_count > CNT_W'(LANES)) ? CNT_W'(LANES) : item_i.point_count;

  always_ff @(posedge clk_i) begin
    if (item_acc) begin
      op_q  <= item_i.op;
      now_q <= item_i.now_ms;
      cnt_q <= cnt_d;
    end
  end

  // Point lanes, each zeroing its point when it lies beyond the count.
  coord_t in_x [POINT_FIELDS];
  coord_t in_y [POINT_FIELDS];
  coord_t lane_x [LANES];
  coord_t lane_y [LANES];

  assign in_x[0] = item_i.x0;
  assign in_x[1] = item_i.x1;
  assign in_x[2] = item_i.x2;
  assign in_x[3] = item_i.x3;
  assign in_y[0] = item_i.y0;
  assign in_y[1] = item_i.y1;
  assign in_y[2] = item_i.y2;
  assign in_y[3] = item_i.y3;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    thq_lane u_lane (
      .clk_i  (clk_i),
      .load_i (item_acc),
      .en_i   (CNT_W'(g) < cnt_d),
      .x_i    (in_x[g]),
      .y_i    (in_y[g]),
      .x_o    (lane_x[g]),
      .y_o    (lane_y[g])
    );
  end

  coord_t avg_x, avg_y;

  thq_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk_i   (clk_i),
    .ctl_i   (merge_ctl),
    .cnt_i   (cnt_q),
    .x_i     (lane_x),
    .y_i     (lane_y),
    .avg_x_o (avg_x),
    .avg_y_o (avg_y)
  );

  // Hold state machine and session state, advanced once per item in the step cycle.
  phase_e phase_q, phase_d;
  logic   session_open_q, session_open_d;
  time_t  session_start_q, session_start_d;
  time_t  press_start_q, press_start_d;
  time_t  gap_start_q, gap_start_d;
  coord_t last_x_q, last_x_d;
  coord_t last_y_q, last_y_d;

  logic     emit;
  outcome_e emit_code;
  coord_t   emit_x, emit_y;
  logic     touched;
  time_t    since_session, since_press, since_gap;

  logic out_valid_q;

  // The step waits only while an earlier result still sits unread.
  assign step_go = (ctl_q == CTL_STEP) && (!out_valid_q || result_o.ready);

  assign touched       = (cnt_q != '0);
  assign since_session = now_q - session_start_q;
  assign since_press   = now_q - press_start_q;
  assign since_gap     = now_q - gap_start_q;

  always_comb begin
    phase_d         = phase_q;
    session_open_d  = session_open_q;
    session_start_d = session_start_q;
    press_start_d   = press_start_q;
    gap_start_d     = gap_start_q;
    last_x_d        = last_x_q;
    last_y_d        = last_y_q;
    emit            = 1'b0;
    emit_code       = OUT_DETECTED;
    emit_x          = '0;
    emit_y          = '0;
    if (op_q == OP_START) begin
      // A start inside a session restarts it and keeps the phase.
      session_open_d  = 1'b1;
      session_start_d = now_q;
    end else if (session_open_q) begin
      if (since_session > timeout_q) begin
        // Timeout keeps the phase and does not look at the touch report.
        emit      = 1'b1;
        emit_code = OUT_TIMEOUT;
      end else begin
        if (touched) begin
          last_x_d = avg_x;
          last_y_d = avg_y;
        end
        case (phase_q)
          PH_TSTART: begin
            press_start_d = now_q;
            phase_d       = PH_TPROG;
          end
          PH_TPROG: begin
            if (since_press > TIME_W'(hold_q)) begin
              phase_d = PH_DET;
            end else if (!touched) begin
              phase_d = PH_GSTART;
            end
          end
          PH_GSTART: begin
            gap_start_d = now_q;
            phase_d     = PH_GPROG;
          end
          PH_GPROG: begin
            if (since_gap > TIME_W'(gap_q)) begin
              phase_d   = PH_IDLE;
              emit      = 1'b1;
              emit_code = OUT_ABANDON;
            end else if (touched) begin
              phase_d = PH_TPROG;
            end
          end
          PH_DET: begin
            phase_d   = PH_IDLE;
            emit      = 1'b1;
            emit_code = OUT_DETECTED;
            emit_x    = last_x_d;
            emit_y    = last_y_d;
          end
          default: begin
            // Idle, and the unused codes, wait for a touch.
            phase_d = touched ? PH_TSTART : PH_IDLE;
          end
        endcase
      end
      // Every result closes the session.
      if (emit) session_open_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_IDLE;
      session_open_q  <= 1'b0;
      session_start_q <= '0;
      press_start_q   <= '0;
      gap_start_q     <= '0;
      last_x_q        <= '0;
      last_y_q        <= '0;
    end else if (step_go) begin
      phase_q         <= phase_d;
      session_open_q  <= session_open_d;
      session_start_q <= session_start_d;
      press_start_q   <= press_start_d;
      gap_start_q     <= gap_start_d;
      last_x_q        <= last_x_d;
      last_y_q        <= last_y_d;
    end
  end

  // Output register. A new result may replace one that is taken in the same cycle.
  logic [1:0] outcome_q;
  coord_t     x_out_q, y_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_go && emit) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_go && emit) begin
      outcome_q <= emit_code;
      x_out_q   <= emit_x;
      y_out_q   <= emit_y;
    end
  end

  assign result_o.valid   = out_valid_q;
  assign result_o.outcome = outcome_q;
  assign result_o.x_out   = x_out_q;
  assign result_o.y_out   = y_out_q;

`ifndef ASSERT_OFF
  // A result appears only right after a state step.
  a_result_from_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_o.valid) |-> $past(ctl_q) == CTL_STEP)
    else $error("result raised without a state step");

  // Only a detected touch carries a position.
  a_zero_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.outcome != OUT_DETECTED) |->
      (result_o.x_out == '0 && result_o.y_out == '0))
    else $error("nonzero position on a result without detection");

  // Issuing a result closes the session.
  a_result_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_go && emit) |=> !session_open_q)
    else $error("session still open after a result");

  // An accepted item always starts the lane sum.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_acc |=> ctl_q == CTL_SUM)
    else $error("accepted item did not start the lane sum");
`endif

endmodule
